// ===== hdl/gene_network_euler_step_assert.svh =====
// Assertion macros for the gene network Euler step block.
// Used by files that include it; expects clk and rst in scope.
`ifndef GENE_NETWORK_EULER_STEP_ASSERT_SVH
`define GENE_NETWORK_EULER_STEP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GNES_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define GNES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gnes_pkg.sv =====
// Package for the gene network Euler step: fraction width, fixed-point
// constants and constant-folding helpers. No dependencies.
package gnes_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HILL_LAT  = FRAC_BITS + 7;
  localparam int EULER_LAT = 4;

  localparam longint ONE = longint'(1) <<< FRAC_BITS;

  function automatic longint fmul_c(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint unsigned fourth_c(longint unsigned a);
    longint unsigned sq;
    sq = (a * a) >> FRAC_BITS;
    if (sq > 64'hFFFF_FFFF) begin
      sq = 64'hFFFF_FFFF;
    end
    return (sq * sq) >> FRAC_BITS;
  endfunction

  localparam longint A005  = ((longint'(5)    <<< FRAC_BITS) + 500) / 1000;
  localparam longint C2    =  (longint'(2)    <<< FRAC_BITS);
  localparam longint C3    =  (longint'(3)    <<< FRAC_BITS);
  localparam longint C0_4  = ((longint'(4)    <<< FRAC_BITS) + 5) / 10;
  localparam longint C0_36 = ((longint'(36)   <<< FRAC_BITS) + 50) / 100;
  localparam longint C1_5  = ((longint'(15)   <<< FRAC_BITS) + 5) / 10;
  localparam longint C10_94 = ((longint'(1094) <<< FRAC_BITS) + 50) / 100;
  localparam longint C10   =  (longint'(10)   <<< FRAC_BITS);
  localparam longint C2_6  = ((longint'(26)   <<< FRAC_BITS) + 5) / 10;
  localparam longint C0_8  = ((longint'(8)    <<< FRAC_BITS) + 5) / 10;
  localparam longint C29_6 = ((longint'(296)  <<< FRAC_BITS) + 5) / 10;
  localparam longint C0_09 = ((longint'(9)    <<< FRAC_BITS) + 50) / 100;

  localparam longint S_OXY = ((longint'(152) <<< FRAC_BITS) + 5) / 10;
  localparam longint G_OXY =  (longint'(40)  <<< FRAC_BITS);
  localparam longint S_HIF = ((longint'(464) <<< FRAC_BITS) + 50) / 100;
  localparam longint G_HIF = ((longint'(381) <<< FRAC_BITS) + 50) / 100;
  localparam longint S_PDK =  (longint'(5)   <<< FRAC_BITS);
  localparam longint G_PDK = ((longint'(697) <<< FRAC_BITS) + 50) / 100;
  localparam longint S_PDH = ((longint'(22)  <<< FRAC_BITS) + 5) / 10;
  localparam longint G_PDH = ((longint'(14)  <<< FRAC_BITS) + 50) / 100;

  localparam longint unsigned S4_OXY = fourth_c(longint'(S_OXY));
  localparam longint unsigned S4_HIF = fourth_c(longint'(S_HIF));
  localparam longint unsigned S4_PDK = fourth_c(longint'(S_PDK));
  localparam longint unsigned S4_PDH = fourth_c(longint'(S_PDH));

  // constant part of the HIF regulator product
  localparam longint P_HIF = fmul_c(fmul_c(fmul_c(fmul_c(fmul_c(fmul_c(
                               C2, C3), C0_4), C0_36), C1_5), C10_94), C10);

endpackage

// ===== hdl/gnes_delay.sv =====
// Enable-gated delay line for payload words.
// No dependencies.
module gnes_delay #(
  parameter int W = 32,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign dout = sr[N-1];

endmodule

// ===== hdl/gnes_hill.sv =====
// Pipelined shifted Hill term H = 1 + (g-1)*y4/(s4+y4), one quotient bit
// per stage. Depends on gnes_pkg.
module gnes_hill #(
  parameter longint unsigned S4  = 0,
  parameter longint          GM1 = 0
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] y,
  output logic signed [31:0] h
);
  import gnes_pkg::*;

  localparam int Y4W = 64 - FRAC_BITS;
  localparam int DW  = Y4W + 1;
  localparam int QN  = FRAC_BITS + 1;

  logic [31:0]     mag;
  logic [63:0]     sq1;
  logic [63:0]     sq_sh;
  logic [31:0]     y2;
  logic [63:0]     p4;
  logic [63:0]     y4_full;
  logic [Y4W-1:0]  y4;
  logic [DW-1:0]   den;
  logic [DW-1:0]   rem_q [QN];
  logic [DW-1:0]   den_q [QN];
  logic [QN-1:0]   q_q   [QN];
  logic signed [63:0] m_q;

  assign mag     = y[31] ? 32'(-y) : 32'(y);
  assign sq_sh   = sq1 >> FRAC_BITS;
  assign y4_full = p4 >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      sq1 <= 64'(mag) * 64'(mag);
      y2  <= (sq_sh[63:32] != 32'd0) ? 32'hFFFF_FFFF : sq_sh[31:0];
      p4  <= 64'(y2) * 64'(y2);
      y4  <= y4_full[Y4W-1:0];
      den <= DW'(y4_full[Y4W-1:0]) + DW'(S4);
    end
  end

  for (genvar i = 0; i < QN; i++) begin : g_div
    logic [DW:0] sh;
    logic [DW:0] dd;
    logic        ge;
    logic [DW:0] diff;
    if (i == 0) begin : g_first
      assign sh = {2'b00, y4};
      assign dd = {1'b0, den};
      always_ff @(posedge clk) begin
        if (en) begin
          den_q[i] <= den;
          q_q[i]   <= QN'(ge);
        end
      end
    end else begin : g_next
      assign sh = {rem_q[i-1], 1'b0};
      assign dd = {1'b0, den_q[i-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          den_q[i] <= den_q[i-1];
          q_q[i]   <= {q_q[i-1][QN-2:0], ge};
        end
      end
    end
    assign ge   = (sh >= dd);
    assign diff = ge ? (sh - dd) : sh;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= diff[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_q <= GM1 * 64'($signed({1'b0, q_q[QN-1]}));
      h   <= 32'(ONE + (m_q >>> FRAC_BITS));
    end
  end

endmodule

// ===== hdl/gnes_scale.sv =====
// One-stage multiply by a fixed-point constant with floor shift.
// Depends on gnes_pkg.
module gnes_scale #(
  parameter longint C  = 0,
  parameter int     IW = 32,
  parameter int     OW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [IW-1:0] x,
  output logic signed [OW-1:0] y
);
  import gnes_pkg::*;

  logic signed [63:0] prod;

  assign prod = 64'(x) * C;

  always_ff @(posedge clk) begin
    if (en) begin
      y <= OW'(prod >>> FRAC_BITS);
    end
  end

endmodule

// ===== hdl/gnes_euler.sv =====
// Four-stage Euler update level + dt*(0.005*prod - decay*level), saturated.
// Depends on gnes_pkg.
module gnes_euler (
  input  logic               clk,
  input  logic               en,
  input  logic        [30:0] step,
  input  logic signed [31:0] level,
  input  logic signed [31:0] decay,
  input  logic signed [31:0] prod,
  output logic signed [31:0] level_new
);
  import gnes_pkg::*;

  localparam int RW = 36;
  localparam int XW = RW + 32;

  logic signed [63:0] m1, m2;
  logic signed [RW-1:0] rate;
  logic signed [XW-1:0] x;
  logic signed [31:0] lv1, lv2, lv3;
  logic signed [63:0] m1_sh, m2_sh;
  logic signed [XW-1:0] sum;

  assign m1_sh = m1 >>> FRAC_BITS;
  assign m2_sh = m2 >>> FRAC_BITS;
  assign sum   = XW'(lv3) + (x >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      m1   <= A005 * 64'(prod);
      m2   <= 64'(decay) * 64'(level);
      lv1  <= level;
      rate <= RW'(m1_sh - m2_sh);
      lv2  <= lv1;
      x    <= XW'($signed({1'b0, step})) * XW'(rate);
      lv3  <= lv2;
      if (sum > XW'(64'sh7FFF_FFFF)) begin
        level_new <= 32'sh7FFF_FFFF;
      end else if (sum < -XW'(64'sh8000_0000)) begin
        level_new <= 32'sh8000_0000;
      end else begin
        level_new <= sum[31:0];
      end
    end
  end

endmodule

// ===== hdl/gene_network_euler_step.sv =====
// Top level of the gene network Euler step block.
// Depends on gnes_pkg, gnes_hill, gnes_scale, gnes_euler, gnes_delay.
//
// Usage:
//   Input channel in_valid/in_stall carries one cell word: oxygen level,
//   the four gene levels and the dead flag. Output channel out_valid/
//   out_stall carries the four levels, unchanged for a dead cell. A word
//   moves at a clock edge where valid is high and stall is low.
//   cfg_wr_en with step_size writes the Euler step; write it only while
//   no word is in flight.
//   The pipeline depth is set by three dependent Hill terms, each with
//   one divider stage per quotient bit, plus the Euler units.
//   Throughput is one word per cycle while the output is not blocked.
//   Reset (rst, synchronous) clears all valid bits and loads step_q
//   with 6.0. While out_stall holds a valid result, the whole pipeline
//   freezes and in_stall is raised; nothing is dropped or repeated.
module gene_network_euler_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic        [30:0] step_size,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [25:0] oxygen_level,
  input  logic signed [31:0] hif_in,
  input  logic signed [31:0] ldh_in,
  input  logic signed [31:0] pdk_in,
  input  logic signed [31:0] pdh_in,
  input  logic               cell_dead,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] hif_out,
  output logic signed [31:0] ldh_out,
  output logic signed [31:0] pdk_out,
  output logic signed [31:0] pdh_out
);
  import gnes_pkg::*;

  localparam int HL  = HILL_LAT;
  localparam int EL  = EULER_LAT;
  localparam int TOT = 3 * HL + 4 * EL;

  logic        en;
  logic [30:0] step_q;
  logic [TOT-1:0] vld;

  logic signed [31:0] h_hif, h_oxy, p_hif, decay_hif, hif_lvl, hif_new;
  logic signed [31:0] h_ldh, h_pdk, p_ldh0, p_ldh, p_pdk0, p_pdk;
  logic signed [31:0] ldh_lvl, pdk_lvl, ldh_new, pdk_new;
  logic signed [31:0] h_pdh, p_pdh, pdh_lvl, pdh_new;
  logic [31:0] hif_pass, ldh_pass, pdk_pass, pdh_pass;
  logic [31:0] hif_new_d, ldh_new_d, pdk_new_d;
  logic [0:0]  dead_d;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q <= 31'd393216;
    end else if (cfg_wr_en) begin
      step_q <= step_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], in_valid};
    end
  end

  // HIF
  gnes_hill #(.S4(S4_HIF), .GM1(G_HIF - ONE)) u_hill_hif (
    .clk(clk), .en(en), .y(hif_in), .h(h_hif));
  gnes_hill #(.S4(S4_OXY), .GM1(G_OXY - ONE)) u_hill_oxy (
    .clk(clk), .en(en), .y($signed({6'd0, oxygen_level})), .h(h_oxy));
  gnes_scale #(.C(P_HIF)) u_p_hif (.clk(clk), .en(en), .x(h_hif), .y(p_hif));
  gnes_scale #(.C(A005)) u_decay (.clk(clk), .en(en), .x(h_oxy), .y(decay_hif));
  gnes_delay #(.W(32), .N(HL + 1)) u_d_hif (
    .clk(clk), .en(en), .din(hif_in), .dout(hif_lvl));
  gnes_euler u_eu_hif (.clk(clk), .en(en), .step(step_q), .level(hif_lvl),
    .decay(decay_hif), .prod(p_hif), .level_new(hif_new));

  // LDH and PDK
  gnes_hill #(.S4(S4_HIF), .GM1(G_HIF - ONE)) u_hill_ldh (
    .clk(clk), .en(en), .y(hif_new), .h(h_ldh));
  gnes_hill #(.S4(S4_PDK), .GM1(G_PDK - ONE)) u_hill_pdk (
    .clk(clk), .en(en), .y(hif_new), .h(h_pdk));
  gnes_scale #(.C(C2_6)) u_p_ldh (.clk(clk), .en(en), .x(h_ldh), .y(p_ldh0));
  gnes_delay #(.W(32), .N(1)) u_d_pldh (
    .clk(clk), .en(en), .din(p_ldh0), .dout(p_ldh));
  gnes_scale #(.C(C0_8)) u_p_pdk0 (.clk(clk), .en(en), .x(h_pdk), .y(p_pdk0));
  gnes_scale #(.C(C29_6)) u_p_pdk (.clk(clk), .en(en), .x(p_pdk0), .y(p_pdk));
  gnes_delay #(.W(32), .N(2 * HL + EL + 3)) u_d_ldh (
    .clk(clk), .en(en), .din(ldh_in), .dout(ldh_lvl));
  gnes_delay #(.W(32), .N(2 * HL + EL + 3)) u_d_pdk (
    .clk(clk), .en(en), .din(pdk_in), .dout(pdk_lvl));
  gnes_euler u_eu_ldh (.clk(clk), .en(en), .step(step_q), .level(ldh_lvl),
    .decay(32'(A005)), .prod(p_ldh), .level_new(ldh_new));
  gnes_euler u_eu_pdk (.clk(clk), .en(en), .step(step_q), .level(pdk_lvl),
    .decay(32'(A005)), .prod(p_pdk), .level_new(pdk_new));

  // PDH
  gnes_hill #(.S4(S4_PDH), .GM1(G_PDH - ONE)) u_hill_pdh (
    .clk(clk), .en(en), .y(pdk_new), .h(h_pdh));
  gnes_scale #(.C(C0_09)) u_p_pdh (.clk(clk), .en(en), .x(h_pdh), .y(p_pdh));
  gnes_delay #(.W(32), .N(3 * HL + 2 * EL + 4)) u_d_pdh (
    .clk(clk), .en(en), .din(pdh_in), .dout(pdh_lvl));
  gnes_euler u_eu_pdh (.clk(clk), .en(en), .step(step_q), .level(pdh_lvl),
    .decay(32'(A005)), .prod(p_pdh), .level_new(pdh_new));

  // alignment to the output stage
  gnes_delay #(.W(32), .N(TOT - HL - 1)) u_a_hif (
    .clk(clk), .en(en), .din(hif_lvl), .dout(hif_pass));
  gnes_delay #(.W(32), .N(TOT - 2 * HL - EL - 3)) u_a_ldh (
    .clk(clk), .en(en), .din(ldh_lvl), .dout(ldh_pass));
  gnes_delay #(.W(32), .N(TOT - 2 * HL - EL - 3)) u_a_pdk (
    .clk(clk), .en(en), .din(pdk_lvl), .dout(pdk_pass));
  gnes_delay #(.W(32), .N(EL)) u_a_pdh (
    .clk(clk), .en(en), .din(pdh_lvl), .dout(pdh_pass));
  gnes_delay #(.W(32), .N(TOT - HL - EL - 1)) u_a_hifn (
    .clk(clk), .en(en), .din(hif_new), .dout(hif_new_d));
  gnes_delay #(.W(32), .N(TOT - 2 * HL - 2 * EL - 3)) u_a_ldhn (
    .clk(clk), .en(en), .din(ldh_new), .dout(ldh_new_d));
  gnes_delay #(.W(32), .N(TOT - 2 * HL - 2 * EL - 3)) u_a_pdkn (
    .clk(clk), .en(en), .din(pdk_new), .dout(pdk_new_d));
  gnes_delay #(.W(1), .N(TOT)) u_a_dead (
    .clk(clk), .en(en), .din(cell_dead), .dout(dead_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hif_out <= dead_d[0] ? hif_pass : hif_new_d;
      ldh_out <= dead_d[0] ? ldh_pass : ldh_new_d;
      pdk_out <= dead_d[0] ? pdk_pass : pdk_new_d;
      pdh_out <= dead_d[0] ? pdh_pass : pdh_new;
    end
  end

  `include "gene_network_euler_step_assert.svh"

  `GNES_ASSERT_SAME(a_stall_when_blocked, out_valid && out_stall, in_stall,
    "input not stalled while output blocked")
  `GNES_ASSERT_SAME(a_no_stall_when_empty, !out_valid, !in_stall,
    "input stalled with empty output")
  `GNES_ASSERT_NEXT(a_hold_on_stall, in_stall, out_valid,
    "output word lost during stall")
  `GNES_ASSERT_NEXT(a_pipe_to_out, !in_stall && vld[TOT-1], out_valid,
    "pipeline word not delivered to output")

endmodule
